/* sv/otpa_pkg.sv */
`timescale 1ns / 1ps

package otpa_pkg;

   // Fixed field widths of the channels
   localparam int WORD_WIDTH  = 64;
   localparam int LANE_WIDTH  = 16;
   localparam int VAL_WIDTH   = 48;
   localparam int INDEX_WIDTH = 5;

   // Item kinds on the request channel
   localparam logic MODE_STEP = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic                   take_step;   // accepted rank-one step
      logic                   take_load;   // accepted prior-tile entry
      logic                   emit_load;   // load output register with one entry
      logic [INDEX_WIDTH-1:0] emit_index;  // column-major entry being emitted
      logic                   emit_last;   // final entry of the tile
      logic                   clear;       // wipe accumulators and prior tile
   } otpa_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;   // output register can take an entry this cycle
   } otpa_sts_type;

endpackage

/* sv/otpa_if.sv */
`timescale 1ns / 1ps

// Request channel: step items and prior-tile loads
interface otpa_req_if import otpa_pkg::*;;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [WORD_WIDTH-1:0]         a_low;
   logic [WORD_WIDTH-1:0]         a_high;
   logic [WORD_WIDTH-1:0]         b_row;
   logic                          last_step;
   logic [INDEX_WIDTH-1:0]        entry_index;
   logic signed [VAL_WIDTH-1:0]   prior_value;

   modport source (output valid, mode, a_low, a_high, b_row, last_step, entry_index,
                   prior_value, input ready);
   modport sink   (input valid, mode, a_low, a_high, b_row, last_step, entry_index,
                   prior_value, output ready);
endinterface

// Response channel: emitted tile entries
interface otpa_rsp_if import otpa_pkg::*;;
   logic                          valid;
   logic                          ready;
   logic [INDEX_WIDTH-1:0]        tile_index;
   logic signed [VAL_WIDTH-1:0]   tile_value;
   logic                          tile_last;

   modport source (output valid, tile_index, tile_value, tile_last, input ready);
   modport sink   (input valid, tile_index, tile_value, tile_last, output ready);
endinterface

// Register write channel: the accumulate bit
interface otpa_csr_if;
   logic valid;
   logic ready;
   logic accumulate;

   modport source (output valid, accumulate, input ready);
   modport sink   (input valid, accumulate, output ready);
endinterface

/* sv/otpa_ctrl.sv */
`timescale 1ns / 1ps

module otpa_ctrl
   import otpa_pkg::*;
#(
   parameter int TILE_SIZE = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_mode,
   input  logic         req_last_step,
   output logic         req_ready,
   input  otpa_sts_type sts,
   output otpa_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DRAIN = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [INDEX_WIDTH-1:0] count_ff, count_in;
   logic                   accept;
   logic                   at_end;

   // Items are taken only between tiles
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign at_end    = (count_ff == INDEX_WIDTH'(TILE_SIZE - 1));

   // Sequencer: idle -> drain product stage -> emit entries
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      cmd            = '0;
      cmd.take_step  = accept && (req_mode == MODE_STEP);
      cmd.take_load  = accept && (req_mode == MODE_LOAD);
      cmd.emit_index = count_ff;
      cmd.emit_last  = at_end;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.take_step && req_last_step) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            count_in = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               if (at_end) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   // last step leads to the drain state, then emission
   a_last_drain: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_step && req_last_step) |=> (state_ff == ST_DRAIN) ##1 (state_ff == ST_EMIT))
      else $error("last step did not start emission");
   // emission counter stays inside the tile
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |->
         ((INDEX_WIDTH + 1)'(count_ff) < (INDEX_WIDTH + 1)'(TILE_SIZE)))
      else $error("emission index beyond tile");
   // stores are wiped only with the final entry
   a_clear_last: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> (cmd.emit_load && cmd.emit_last))
      else $error("clear without final entry");
`endif

endmodule

/* sv/otpa_datapath.sv */
`timescale 1ns / 1ps

module otpa_datapath
   import otpa_pkg::*;
#(
   parameter int ROWS       = 8,
   parameter int COLS       = 4,
   parameter int ELEM_WIDTH = 16,
   parameter int ACC_WIDTH  = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  otpa_cmd_type                cmd,
   output otpa_sts_type                sts,
   // request payload
   input  logic [WORD_WIDTH-1:0]       a_low,
   input  logic [WORD_WIDTH-1:0]       a_high,
   input  logic [WORD_WIDTH-1:0]       b_row,
   input  logic [INDEX_WIDTH-1:0]      entry_index,
   input  logic signed [VAL_WIDTH-1:0] prior_value,
   // register write
   input  logic                        csr_valid,
   input  logic                        csr_accumulate,
   output logic                        csr_ready,
   // response
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [INDEX_WIDTH-1:0]      rsp_tile_index,
   output logic signed [VAL_WIDTH-1:0] rsp_tile_value,
   output logic                        rsp_tile_last
);

   localparam int TILE_SIZE = ROWS * COLS;
   localparam int IDX_W     = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
   localparam int PROD_W    = 2 * ELEM_WIDTH;
   localparam int WIDE_W    = (ACC_WIDTH > VAL_WIDTH) ? ACC_WIDTH : VAL_WIDTH;
   localparam int SUM_W     = WIDE_W + 1;

   logic                        accumulate_ff;
   logic                        step_v_ff;
   logic signed [PROD_W-1:0]    prod_ff  [TILE_SIZE];
   logic signed [ACC_WIDTH-1:0] acc_ff   [TILE_SIZE];
   logic signed [ACC_WIDTH-1:0] acc_in   [TILE_SIZE];
   logic signed [VAL_WIDTH-1:0] prior_ff [TILE_SIZE];
   logic                        prior_hit;

   logic                        rsp_valid_ff;
   logic [INDEX_WIDTH-1:0]      tile_index_ff;
   logic signed [VAL_WIDTH-1:0] tile_value_ff;
   logic                        tile_last_ff;

   logic signed [ACC_WIDTH-1:0] acc_sel;
   logic signed [VAL_WIDTH-1:0] prior_sel;
   logic signed [SUM_W-1:0]     tot_sum;
   logic [SUM_W-ACC_WIDTH:0]    tot_top;
   logic signed [ACC_WIDTH-1:0] tot_sat;
   logic signed [ACC_WIDTH-1:0] chosen;
   logic signed [WIDE_W-1:0]    chosen_ext;
   logic [WIDE_W-VAL_WIDTH:0]   out_top;
   logic signed [VAL_WIDTH-1:0] out_value;

   // Accumulate bit; writes come only while idle, a rule the block itself does not enforce
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         accumulate_ff <= 1'b0;
      end else if (csr_valid) begin
         accumulate_ff <= csr_accumulate;
      end
   end

   // Product stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         step_v_ff <= 1'b0;
      end else begin
         step_v_ff <= cmd.take_step;
      end
   end

   // One MAC lane per tile entry: multiply, register, saturating add
   for (genvar j = 0; j < COLS; j++) begin : g_col
      for (genvar i = 0; i < ROWS; i++) begin : g_row
         localparam int K = j * ROWS + i;
         logic signed [ELEM_WIDTH-1:0] a_elem;
         logic signed [ELEM_WIDTH-1:0] b_elem;
         logic signed [ACC_WIDTH:0]    lane_sum;

         if (i < 4) begin : g_lo
            assign a_elem = a_low[LANE_WIDTH*i +: ELEM_WIDTH];
         end else begin : g_hi
            assign a_elem = a_high[LANE_WIDTH*(i-4) +: ELEM_WIDTH];
         end
         assign b_elem = b_row[LANE_WIDTH*j +: ELEM_WIDTH];

         always_ff @(posedge clock) begin
            if (cmd.take_step) begin
               prod_ff[K] <= PROD_W'(a_elem) * PROD_W'(b_elem);
            end
         end

         // clamp on overflow of the accumulator range
         always_comb begin
            lane_sum = (ACC_WIDTH + 1)'(acc_ff[K]) + (ACC_WIDTH + 1)'(prod_ff[K]);
            if (lane_sum[ACC_WIDTH] != lane_sum[ACC_WIDTH-1]) begin
               acc_in[K] = {lane_sum[ACC_WIDTH], {(ACC_WIDTH-1){~lane_sum[ACC_WIDTH]}}};
            end else begin
               acc_in[K] = lane_sum[ACC_WIDTH-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset || cmd.clear) begin
               acc_ff[K] <= '0;
            end else if (step_v_ff) begin
               acc_ff[K] <= acc_in[K];
            end
         end
      end
   end

   // Prior tile: entries beyond the tile are dropped
   assign prior_hit = ((INDEX_WIDTH + 1)'(entry_index) < (INDEX_WIDTH + 1)'(TILE_SIZE));
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int n = 0; n < TILE_SIZE; n++) begin
            prior_ff[n] <= '0;
         end
      end else if (cmd.take_load && prior_hit) begin
         prior_ff[entry_index[IDX_W-1:0]] <= prior_value;
      end
   end

   // Emitted entry: optional prior add, clamp to accumulator, then to output range
   always_comb begin
      acc_sel   = acc_ff[cmd.emit_index[IDX_W-1:0]];
      prior_sel = prior_ff[cmd.emit_index[IDX_W-1:0]];
      tot_sum   = SUM_W'(prior_sel) + SUM_W'(acc_sel);
      tot_top   = tot_sum[SUM_W-1:ACC_WIDTH-1];
      if ((&tot_top) || !(|tot_top)) begin
         tot_sat = tot_sum[ACC_WIDTH-1:0];
      end else begin
         tot_sat = {tot_sum[SUM_W-1], {(ACC_WIDTH-1){~tot_sum[SUM_W-1]}}};
      end
      chosen     = accumulate_ff ? tot_sat : acc_sel;
      chosen_ext = WIDE_W'(chosen);
      out_top    = chosen_ext[WIDE_W-1:VAL_WIDTH-1];
      if ((&out_top) || !(|out_top)) begin
         out_value = chosen_ext[VAL_WIDTH-1:0];
      end else begin
         out_value = {chosen_ext[WIDE_W-1], {(VAL_WIDTH-1){~chosen_ext[WIDE_W-1]}}};
      end
   end

   // Output register
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         tile_index_ff <= cmd.emit_index;
         tile_value_ff <= out_value;
         tile_last_ff  <= cmd.emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tile_index = tile_index_ff;
   assign rsp_tile_value = tile_value_ff;
   assign rsp_tile_last  = tile_last_ff;

`ifndef SYNTHESIS
   // never overwrite an entry still waiting on the response side
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("output entry overwritten");
   // product stage is empty when the stores are wiped
   a_clear_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !step_v_ff)
      else $error("clear while product stage busy");
`endif

endmodule

/* sv/outer_product_tile_accumulator.sv */
`timescale 1ns / 1ps

// Channel   Dir  Modport  Payload
// req_if    in   sink     mode, a_low, a_high, b_row, last_step, entry_index, prior_value
// rsp_if    out  source   tile_index, tile_value, tile_last
// csr_if    in   sink     accumulate
//
// Step and load transactions are taken one per cycle while no tile is being drained or emitted.
// A last step passes the product register and the drain state, then ROWS*COLS entries are emitted
// one at a time (held while rsp_if stalls); the single read port through the tile store sets this.
// Reset is synchronous; it clears the accumulators, the prior tile and accumulate.
// A stalled response holds its entry; the next entry waits in the sequencer.
module outer_product_tile_accumulator
   import otpa_pkg::*;
#(
   parameter int ROWS       = 8,
   parameter int COLS       = 4,
   parameter int ELEM_WIDTH = 16,
   parameter int ACC_WIDTH  = 48
) (
   input  logic      clock,
   input  logic      reset,
   otpa_req_if.sink   req_if,
   otpa_rsp_if.source rsp_if,
   otpa_csr_if.sink   csr_if
);

   otpa_cmd_type cmd;
   otpa_sts_type sts;

   // Sequencer
   otpa_ctrl #(
      .TILE_SIZE (ROWS * COLS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_mode      (req_if.mode),
      .req_last_step (req_if.last_step),
      .req_ready     (req_if.ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   // MAC lanes, tile stores and output register
   otpa_datapath #(
      .ROWS       (ROWS),
      .COLS       (COLS),
      .ELEM_WIDTH (ELEM_WIDTH),
      .ACC_WIDTH  (ACC_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .a_low          (req_if.a_low),
      .a_high         (req_if.a_high),
      .b_row          (req_if.b_row),
      .entry_index    (req_if.entry_index),
      .prior_value    (req_if.prior_value),
      .csr_valid      (csr_if.valid),
      .csr_accumulate (csr_if.accumulate),
      .csr_ready      (csr_if.ready),
      .rsp_ready      (rsp_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_tile_index (rsp_if.tile_index),
      .rsp_tile_value (rsp_if.tile_value),
      .rsp_tile_last  (rsp_if.tile_last)
   );

endmodule

/* bench/otpa_tile_checker.sv */
`timescale 1ns / 1ps

// Watches the three channels of the tile accumulator, predicts every emitted tile
// entry and compares it against the response transactions.
module otpa_tile_checker
   import otpa_pkg::*;
#(
   parameter int ROWS = 8,
   parameter int COLS = 4
) (
   input  logic clock,
   input  logic reset,
   otpa_req_if  req_if,
   otpa_rsp_if  rsp_if,
   otpa_csr_if  csr_if,
   output int   mismatch_count,
   output int   entries_pending
);

   localparam int TILE_ENTRIES = ROWS * COLS;
   // accumulators and outputs are both VAL_WIDTH wide in this configuration
   localparam logic signed [VAL_WIDTH-1:0] VAL_MAX = {1'b0, {(VAL_WIDTH-1){1'b1}}};
   localparam logic signed [VAL_WIDTH-1:0] VAL_MIN = {1'b1, {(VAL_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic [INDEX_WIDTH-1:0]      index;
      logic signed [VAL_WIDTH-1:0] value;
      logic                        last;
   } tile_entry_type;

   tile_entry_type              tile_entry_q[$];
   logic signed [VAL_WIDTH-1:0] sum_tile[TILE_ENTRIES];
   logic signed [VAL_WIDTH-1:0] prior_tile[TILE_ENTRIES];
   logic                        add_prior;
   int                          errors = 0;

   // Two's complement add, clamped to the VAL_WIDTH signed range
   function automatic logic signed [VAL_WIDTH-1:0] sat_add(
      input logic signed [VAL_WIDTH-1:0] x,
      input logic signed [VAL_WIDTH-1:0] y
   );
      logic [VAL_WIDTH:0] s;
      s = {x[VAL_WIDTH-1], x} + {y[VAL_WIDTH-1], y};
      if (s[VAL_WIDTH] != s[VAL_WIDTH-1]) begin
         return s[VAL_WIDTH] ? VAL_MIN : VAL_MAX;
      end
      return s[VAL_WIDTH-1:0];
   endfunction

   // Update the tile model with one accepted request transaction
   task automatic predict_request();
      logic signed [LANE_WIDTH-1:0]   a_elem;
      logic signed [LANE_WIDTH-1:0]   b_elem;
      logic signed [2*LANE_WIDTH-1:0] prod;
      logic signed [VAL_WIDTH-1:0]    prod_wide;
      tile_entry_type                 entry;
      int                             k;
      if (req_if.mode == MODE_LOAD) begin
         // prior entry write, no response
         if (req_if.entry_index < TILE_ENTRIES) begin
            prior_tile[req_if.entry_index] = req_if.prior_value;
         end
      end else begin
         // rank-one update, column-major accumulator order
         for (int j = 0; j < COLS; j++) begin
            b_elem = req_if.b_row[LANE_WIDTH*j +: LANE_WIDTH];
            for (int i = 0; i < ROWS; i++) begin
               if (i < 4) begin
                  a_elem = req_if.a_low[LANE_WIDTH*i +: LANE_WIDTH];
               end else begin
                  a_elem = req_if.a_high[LANE_WIDTH*(i-4) +: LANE_WIDTH];
               end
               prod      = (2*LANE_WIDTH)'(a_elem) * (2*LANE_WIDTH)'(b_elem);
               prod_wide = prod;
               k         = j * ROWS + i;
               sum_tile[k] = sat_add(sum_tile[k], prod_wide);
            end
         end
         // last step: queue the whole tile, then clear both stores
         if (req_if.last_step) begin
            for (int n = 0; n < TILE_ENTRIES; n++) begin
               entry.index = INDEX_WIDTH'(n);
               entry.value = add_prior ? sat_add(prior_tile[n], sum_tile[n]) : sum_tile[n];
               entry.last  = (n == TILE_ENTRIES - 1);
               tile_entry_q.push_back(entry);
               sum_tile[n]   = '0;
               prior_tile[n] = '0;
            end
         end
      end
   endtask

   // Compare one response transaction with the oldest predicted entry
   task automatic check_entry();
      tile_entry_type want;
      if (tile_entry_q.size() == 0) begin
         $error("tile entry %0d arrived with none predicted", rsp_if.tile_index);
         errors++;
      end else begin
         want = tile_entry_q.pop_front();
         if (rsp_if.tile_index !== want.index) begin
            $error("tile_index: expected %0d, actual %0d", want.index, rsp_if.tile_index);
            errors++;
         end
         if (rsp_if.tile_value !== want.value) begin
            $error("tile_value: expected %0d, actual %0d", $signed(want.value),
                   $signed(rsp_if.tile_value));
            errors++;
         end
         if (rsp_if.tile_last !== want.last) begin
            $error("tile_last: expected %0d, actual %0d", want.last, rsp_if.tile_last);
            errors++;
         end
      end
   endtask

   // Sample all channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         tile_entry_q.delete();
         for (int n = 0; n < TILE_ENTRIES; n++) begin
            sum_tile[n]   = '0;
            prior_tile[n] = '0;
         end
         add_prior = 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_entry();
         end
         if (csr_if.valid && csr_if.ready) begin
            add_prior = csr_if.accumulate;
         end
         if (req_if.valid && req_if.ready) begin
            predict_request();
         end
      end
      mismatch_count  <= errors;
      entries_pending <= tile_entry_q.size();
   end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb import otpa_pkg::*;;

   localparam int TILE_ENTRIES  = 32;
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int SAT_STEPS     = 8;
   localparam int HALF_ITEMS    = 60;
   localparam logic [VAL_WIDTH-1:0] VAL_MAX = {1'b0, {(VAL_WIDTH-1){1'b1}}};
   localparam logic [VAL_WIDTH-1:0] VAL_MIN = {1'b1, {(VAL_WIDTH-1){1'b0}}};

   logic clock = 1'b0;
   logic reset;
   logic rsp_hold;
   int   send_idle_pct = 22;
   int   recv_idle_pct = 87;
   int   phase_num     = 1;
   int   items_sent    = 0;
   int   cycle_count   = 0;
   int   mismatch_count;
   int   entries_pending;

   otpa_req_if req_if ();
   otpa_rsp_if rsp_if ();
   otpa_csr_if csr_if ();

   outer_product_tile_accumulator i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   otpa_tile_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .rsp_if          (rsp_if),
      .csr_if          (csr_if),
      .mismatch_count  (mismatch_count),
      .entries_pending (entries_pending)
   );

   // 12 ns clock
   always #6 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Response side: random back-pressure plus the long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Long response stall at the start of the no-idle phase, so the tile store backs up
   initial begin
      rsp_hold <= 1'b0;
      wait (phase_num == 3);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Element picker, biased toward the Q1.15 extremes
   function automatic logic [LANE_WIDTH-1:0] pick_lane();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return 16'h0001;
         default: return LANE_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic [WORD_WIDTH-1:0] pick_word();
      return {pick_lane(), pick_lane(), pick_lane(), pick_lane()};
   endfunction

   function automatic logic [VAL_WIDTH-1:0] pick_prior();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(5))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return '0;
         3: return '1;
         default: return raw[VAL_WIDTH-1:0];
      endcase
   endfunction

   // One request transaction, with random idle cycles in front of it
   task automatic push_request(
      input logic                   mode,
      input logic [WORD_WIDTH-1:0]  a_lo,
      input logic [WORD_WIDTH-1:0]  a_hi,
      input logic [WORD_WIDTH-1:0]  b,
      input logic                   last,
      input logic [INDEX_WIDTH-1:0] idx,
      input logic [VAL_WIDTH-1:0]   val
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.mode        <= mode;
      req_if.a_low       <= a_lo;
      req_if.a_high      <= a_hi;
      req_if.b_row       <= b;
      req_if.last_step   <= last;
      req_if.entry_index <= idx;
      req_if.prior_value <= val;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   // Step transaction; index and prior fields carry noise
   task automatic send_step(
      input logic [WORD_WIDTH-1:0] a_lo,
      input logic [WORD_WIDTH-1:0] a_hi,
      input logic [WORD_WIDTH-1:0] b,
      input logic                  last
   );
      push_request(MODE_STEP, a_lo, a_hi, b, last,
                   INDEX_WIDTH'($urandom_range(TILE_ENTRIES - 1)), pick_prior());
   endtask

   // Prior-entry load; operand and last fields carry noise
   task automatic send_load(input logic [INDEX_WIDTH-1:0] idx, input logic [VAL_WIDTH-1:0] val);
      push_request(MODE_LOAD, pick_word(), pick_word(), pick_word(), 1'($urandom_range(1)),
                   idx, val);
   endtask

   // Register write once every predicted entry is out and the pipe has drained
   task automatic write_accumulate(input logic value);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (entries_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_if.valid      <= 1'b1;
      csr_if.accumulate <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   // Mostly well-formed tiles (loads, then k steps ending in last), some loose noise
   task automatic run_random(input int item_count);
      int first_item;
      int loads;
      int steps;
      first_item = items_sent;
      while (items_sent - first_item < item_count) begin
         if ($urandom_range(99) < 85) begin
            loads = $urandom_range(4);
            repeat (loads) send_load(INDEX_WIDTH'($urandom_range(TILE_ENTRIES - 1)),
                                     pick_prior());
            steps = ($urandom_range(9) == 0) ? $urandom_range(16, 8) : $urandom_range(4, 1);
            for (int s = 0; s < steps; s++) begin
               send_step(pick_word(), pick_word(), pick_word(), s == steps - 1);
            end
         end else if ($urandom_range(1) == 0) begin
            send_load(INDEX_WIDTH'($urandom_range(TILE_ENTRIES - 1)), pick_prior());
         end else begin
            send_step(pick_word(), pick_word(), pick_word(), $urandom_range(3) == 0);
         end
      end
   endtask

   // Stimulus and verdict
   initial begin
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.mode        <= MODE_STEP;
      req_if.a_low       <= '0;
      req_if.a_high      <= '0;
      req_if.b_row       <= '0;
      req_if.last_step   <= 1'b0;
      req_if.entry_index <= '0;
      req_if.prior_value <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.accumulate  <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes in overwrite mode
      write_accumulate(1'b0);
      send_step({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 1'b0);
      send_step({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 1'b0);
      send_step({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                {16'h0001, 16'hFFFF, 16'h0000, 16'h8000},
                {16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF}, 1'b1);
      // loads are ignored on output in overwrite mode, but still cleared
      send_load(0, VAL_MAX);
      send_load(31, VAL_MIN);
      send_load(5, '1);
      // load with last and busy operands must not emit
      push_request(MODE_LOAD, '1, '1, '1, 1'b1, 12, 48'h0000_1234_5678);
      send_step({4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'h0001}}, 1'b1);

      // Directed: accumulate mode, prior+sum saturating both ways
      write_accumulate(1'b1);
      send_load(0, VAL_MAX);
      send_load(7, VAL_MIN);
      send_load(16, VAL_MIN);
      send_load(31, '1);
      send_load(8, 48'h0123_4567_89AB);
      send_load(8, 48'h8000_0000_0001);
      send_step({4{16'h7FFF}}, {4{16'h7FFF}}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF}, 1'b1);
      // stores were cleared by the emission: all-zero tile
      send_step('0, '0, '0, 1'b1);
      send_step({4{16'h0001}}, {4{16'h8000}}, {4{16'h0001}}, 1'b1);

      // Random, slow sender against a very slow receiver
      write_accumulate(1'b1);
      run_random(HALF_ITEMS);
      write_accumulate(1'b0);
      run_random(HALF_ITEMS);

      // Random, very slow sender against a slow receiver
      send_idle_pct = 87;
      recv_idle_pct = 22;
      write_accumulate(1'b0);
      run_random(HALF_ITEMS);
      write_accumulate(1'b1);
      run_random(HALF_ITEMS);

      // Random, no idling, with the long response hold at the start
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_accumulate(1'($urandom_range(1)));
      phase_num = 3;
      run_random(HALF_ITEMS);
      write_accumulate(1'($urandom_range(1)));
      run_random(HALF_ITEMS);

      // Extreme priors pushed further out: columns 0,1 grow, columns 2,3 shrink
      write_accumulate(1'b1);
      send_load(0, VAL_MAX);
      send_load(1, VAL_MIN);
      send_load(16, VAL_MIN);
      send_load(17, VAL_MAX);
      for (int s = 0; s < SAT_STEPS; s++) begin
         send_step({4{16'h8000}}, {4{16'h8000}}, {16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000},
                   s == SAT_STEPS - 1);
      end

      // Drain and verdict
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (entries_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/otpa_pkg.sv
sv/otpa_if.sv
sv/otpa_ctrl.sv
sv/otpa_datapath.sv
sv/outer_product_tile_accumulator.sv
bench/otpa_tile_checker.sv
bench/tb.sv
